// ===== src/hcbd_pkg.sv =====
`timescale 1ns / 1ps

package hcbd_pkg;

  localparam int SIZE_BITS_DEF = 32;

  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_LF = 8'd10;

  // Character code offsets for hex digit conversion
  localparam logic [7:0] OFS_DIGIT = 8'd48;  // '0'
  localparam logic [7:0] OFS_LOWER = 8'd87;  // 'a' - 10
  localparam logic [7:0] OFS_UPPER = 8'd55;  // 'A' - 10

  localparam int HEX_RADIX_BITS = 4;         // one hex digit, radix 16

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  // Status handed back from the size accumulator
  typedef struct packed {
    logic is_hex;
    logic sat;
  } digit_status_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t h;
    logic [7:0] diff;
    h    = '0;
    diff = '0;
    if (c >= 8'd48 && c <= 8'd57) begin
      diff = c - OFS_DIGIT;
      h.valid = 1'b1;
    end else if (c >= 8'd97 && c <= 8'd102) begin
      diff = c - OFS_LOWER;
      h.valid = 1'b1;
    end else if (c >= 8'd65 && c <= 8'd70) begin
      diff = c - OFS_UPPER;
      h.valid = 1'b1;
    end
    h.value = diff[3:0];
    return h;
  endfunction

endpackage

// ===== src/hcbd_size_acc.sv =====
`timescale 1ns / 1ps

// One hex digit into the chunk size: shift by four and add, saturating
// when the top digit is already occupied.
module hcbd_size_acc #(
  parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  logic [SIZE_BITS-1:0]   acc,
  input  logic [7:0]             in_byte,
  output logic [SIZE_BITS-1:0]   acc_nxt,
  output hcbd_pkg::digit_status_t status
);

  hcbd_pkg::hex_digit_t hex;
  logic                 top_busy;

  assign hex      = hcbd_pkg::hex_decode(in_byte);
  // acc * 16 + d exceeds the maximum exactly when the top nibble is non-zero
  assign top_busy = |acc[SIZE_BITS-1 -: hcbd_pkg::HEX_RADIX_BITS];

  always_comb begin
    status.is_hex = hex.valid;
    status.sat    = hex.valid & top_busy;
    if (!hex.valid) begin
      acc_nxt = acc;
    end else if (top_busy) begin
      acc_nxt = '1;
    end else begin
      acc_nxt = {acc[SIZE_BITS-hcbd_pkg::HEX_RADIX_BITS-1:0], hex.value};
    end
  end

endmodule

// ===== src/http_chunked_body_decoder_core.sv =====
`timescale 1ns / 1ps

// HTTP chunked body decoder. Raw response bytes go in, one per transaction,
// and decoded body bytes come out. Header bytes are dropped up to and
// including CR LF CR LF; a transaction flagged start_of_response (in_tuser)
// restarts at the header with that byte as its first header byte. With
// chunked_mode = 1 the size lines are parsed as hex (either case; other bytes
// on the line, including CR, are ignored), LF loads the size
// and that many data bytes follow, the last one marked with out_tlast. A size
// of zero produces nothing, so the CR LF after each chunk and the final zero
// chunk are silent. A size wider than SIZE_BITS saturates at all ones and the
// data bytes of that chunk carry out_tuser = 1. With chunked_mode = 0 every
// body byte passes straight through. chunked_mode is sampled when the header
// terminator completes, so write it between responses. Every input byte is
// decoded straight into the state registers and the output register, so one
// transaction is accepted per clock while the output register is empty or
// being drained; a body byte is valid at the output in the cycle after its
// acceptance. Throughput drops only when downstream holds off out_tready.
module http_chunked_body_decoder_core #(
  parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration: chunked_mode
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  // raw byte stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic [0:0] in_tuser,   // [0] start_of_response
  // decoded body
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // chunk_end
  output logic [0:0] out_tuser   // [0] size_overflow
);

  // parser phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SIZE   = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_PASS   = 2'd3;

  localparam logic [1:0] MATCH_FULL = 2'd3;

  logic                 mode_r;
  logic [1:0]           phase_r, phase_nxt;
  logic [1:0]           match_r, match_nxt;
  logic [SIZE_BITS-1:0] acc_r, acc_nxt;
  logic [SIZE_BITS-1:0] rem_r, rem_nxt;
  logic                 ovf_r, ovf_nxt;

  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic                 out_last_r;
  logic                 out_ovf_r;

  // effective state after an optional restart
  logic [1:0]           ph_eff;
  logic [1:0]           match_eff;
  logic [SIZE_BITS-1:0] acc_eff;
  logic [SIZE_BITS-1:0] rem_eff;
  logic                 ovf_eff;

  logic                 accept;
  logic [7:0]           b;
  logic                 restart;
  logic [7:0]           term_expect;
  logic                 last_byte;
  logic                 emit;

  logic [SIZE_BITS-1:0]    acc_digit;
  hcbd_pkg::digit_status_t dstat;

  assign cfg_ready = 1'b1;

  // Output register frees up as soon as it is being taken
  assign in_tready = ~out_valid_r | out_tready;
  assign accept    = in_tvalid & in_tready;
  assign b         = in_tdata;
  assign restart   = in_tuser[0];

  assign ph_eff    = restart ? PH_HEADER : phase_r;
  assign match_eff = restart ? 2'd0      : match_r;
  assign acc_eff   = restart ? '0        : acc_r;
  assign rem_eff   = restart ? '0        : rem_r;
  assign ovf_eff   = restart ? 1'b0      : ovf_r;

  // terminator is CR LF CR LF: odd positions expect LF
  assign term_expect = match_eff[0] ? hcbd_pkg::CHAR_LF : hcbd_pkg::CHAR_CR;
  // bytes_remaining <= 1
  assign last_byte   = ~|rem_eff[SIZE_BITS-1:1];

  hcbd_size_acc #(
    .SIZE_BITS (SIZE_BITS)
  ) u_size_acc (
    .acc     (acc_eff),
    .in_byte (b),
    .acc_nxt (acc_digit),
    .status  (dstat)
  );

  always_comb begin
    phase_nxt = ph_eff;
    match_nxt = match_eff;
    acc_nxt   = acc_eff;
    rem_nxt   = rem_eff;
    ovf_nxt   = ovf_eff;
    emit      = 1'b0;
    unique case (ph_eff)
      PH_HEADER: begin
        if (b == term_expect) begin
          if (match_eff == MATCH_FULL) begin
            match_nxt = 2'd0;
            phase_nxt = mode_r ? PH_SIZE : PH_PASS;
          end else begin
            match_nxt = match_eff + 2'd1;
          end
        end else begin
          // a CR that breaks a partial match starts a new one
          match_nxt = (b == hcbd_pkg::CHAR_CR) ? 2'd1 : 2'd0;
        end
      end
      PH_SIZE: begin
        if (b == hcbd_pkg::CHAR_LF) begin
          if (|acc_eff) begin
            rem_nxt   = acc_eff;
            phase_nxt = PH_DATA;
          end else begin
            ovf_nxt = 1'b0;  // zero size: also drops a stale flag
          end
          acc_nxt = '0;
        end else begin
          acc_nxt = acc_digit;
          if (dstat.sat) begin
            ovf_nxt = 1'b1;
          end
        end
      end
      PH_DATA: begin
        emit = 1'b1;
        if (last_byte) begin
          rem_nxt   = '0;
          ovf_nxt   = 1'b0;
          phase_nxt = PH_SIZE;
        end else begin
          rem_nxt = rem_eff - {{(SIZE_BITS-1){1'b0}}, 1'b1};
        end
      end
      PH_PASS: begin
        emit = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b1;
      phase_r     <= PH_HEADER;
      match_r     <= 2'd0;
      acc_r       <= '0;
      rem_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
      if (accept) begin
        phase_r     <= phase_nxt;
        match_r     <= match_nxt;
        acc_r       <= acc_nxt;
        rem_r       <= rem_nxt;
        ovf_r       <= ovf_nxt;
        out_valid_r <= emit;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded only when a byte is emitted
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_byte_r <= b;
      out_last_r <= (ph_eff == PH_DATA) & last_byte;
      out_ovf_r  <= (ph_eff == PH_DATA) & ovf_eff;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_byte_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_ovf_r;

endmodule

// ===== src/hcbd_checker.sv =====
`timescale 1ns / 1ps

module hcbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [0:0] in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [0:0] out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

  // an empty output register never blocks the input side
  a_no_idle_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // a restarted response is in its header: nothing comes out next
  a_restart_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] |=> !out_tvalid)
    else $error("output after start of response");

  // no result appears without an input transaction
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !(in_tvalid && in_tready) |=> !out_tvalid)
    else $error("result without input");

endmodule

bind http_chunked_body_decoder_core hcbd_checker u_hcbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
